>>> rtl/assert_macros.svh
// Assertion macros for the file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/tte_pkg.sv
// Shared types and constants of the text terminal engine.
package tte_pkg;

  localparam int DefaultCols = 80;
  localparam int DefaultRows = 25;

  localparam logic [7:0] BlankChar   = 8'h20;
  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] ResetColor  = 8'h07;

  typedef enum logic [3:0] {
    K_PUTC  = 4'd0,
    K_BACK  = 4'd1,
    K_DEL   = 4'd2,
    K_LEFT  = 4'd3,
    K_RIGHT = 4'd4,
    K_DOWN  = 4'd5,
    K_CLEAR = 4'd6,
    K_MARK  = 4'd7,
    K_READ  = 4'd8
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DISPATCH, ST_COPY, ST_FLUSH, ST_FILL,
    ST_SCAN_RD, ST_SCAN_CHK, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    C_NONE, C_PUTC, C_BACK, C_LEFT_DEC, C_LEFT_HIT, C_LEFT_MISS,
    C_RIGHT, C_DOWN, C_HOME, C_MARK
  } cur_op_e;

  typedef enum logic [2:0] {
    R_ALL, R_SCROLL, R_LAST_ROW, R_SHIFT, R_CUR, R_END
  } range_e;

  typedef struct packed {
    logic    capture;
    cur_op_e cur_op;
    logic    load;
    range_e  range;
    logic    copy_step;
    logic    fill_step;
    logic    fill_init;
    logic    wr_char;
    logic    scan_init;
    logic    scan_dec;
    logic    scan_rd;
    logic    cell_rd;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       is_newline;
    logic       need_scroll;
    logic       cur_le_start;
    logic       col_zero;
    logic       read_ok;
    logic       range_done;
    logic       scan_hit;
    logic       scan_col_zero;
  } status_t;

endpackage

>>> rtl/tte_ctrl.sv
// Sequencing state machine of the text terminal engine.
module tte_ctrl
  import tte_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:     if (status_i.range_done) state_d = ST_IDLE;
      ST_IDLE:     if (start) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (kind_e'(status_i.kind))
          K_PUTC:  state_d = status_i.need_scroll ? ST_COPY : ST_DONE;
          K_BACK:  state_d = status_i.cur_le_start ? ST_DONE : ST_COPY;
          K_DEL:   state_d = ST_FILL;
          K_LEFT:  begin
            if (status_i.cur_le_start || !status_i.col_zero) state_d = ST_DONE;
            else state_d = ST_SCAN_RD;
          end
          K_CLEAR: state_d = ST_FILL;
          default: state_d = ST_DONE;
        endcase
      end
      ST_COPY:     if (status_i.range_done) state_d = ST_FLUSH;
      ST_FLUSH:    state_d = ST_FILL;
      ST_FILL:     if (status_i.range_done) state_d = ST_DONE;
      ST_SCAN_RD:  state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (status_i.scan_hit || status_i.scan_col_zero) state_d = ST_DONE;
        else state_d = ST_SCAN_RD;
      end
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.cur_op = C_NONE;
    cmd_o.range = R_ALL;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.fill_step = !status_i.range_done;
        cmd_o.fill_init = 1'b1;
      end
      ST_IDLE: cmd_o.capture = start;
      ST_DISPATCH: begin
        unique case (kind_e'(status_i.kind))
          K_PUTC: begin
            cmd_o.wr_char = !status_i.is_newline;
            cmd_o.cur_op = C_PUTC;
            cmd_o.load = status_i.need_scroll;
            cmd_o.range = R_SCROLL;
          end
          K_BACK: begin
            if (!status_i.cur_le_start) begin
              cmd_o.cur_op = C_BACK;
              cmd_o.load = 1'b1;
              cmd_o.range = R_SHIFT;
            end
          end
          K_DEL: begin
            cmd_o.load = 1'b1;
            cmd_o.range = R_CUR;
          end
          K_LEFT: begin
            if (!status_i.cur_le_start) begin
              if (status_i.col_zero) cmd_o.scan_init = 1'b1;
              else cmd_o.cur_op = C_LEFT_DEC;
            end
          end
          K_RIGHT: cmd_o.cur_op = C_RIGHT;
          K_DOWN:  cmd_o.cur_op = C_DOWN;
          K_CLEAR: begin
            cmd_o.cur_op = C_HOME;
            cmd_o.load = 1'b1;
            cmd_o.range = R_ALL;
          end
          K_MARK:  cmd_o.cur_op = C_MARK;
          K_READ:  cmd_o.cell_rd = status_i.read_ok;
          default: ;
        endcase
      end
      ST_COPY: cmd_o.copy_step = !status_i.range_done;
      ST_FLUSH: begin
        cmd_o.load = 1'b1;
        cmd_o.range = (kind_e'(status_i.kind) == K_PUTC) ? R_LAST_ROW : R_END;
      end
      ST_FILL: cmd_o.fill_step = !status_i.range_done;
      ST_SCAN_RD: cmd_o.scan_rd = 1'b1;
      ST_SCAN_CHK: begin
        if (status_i.scan_hit) cmd_o.cur_op = C_LEFT_HIT;
        else if (status_i.scan_col_zero) cmd_o.cur_op = C_LEFT_MISS;
        else cmd_o.scan_dec = 1'b1;
      end
      ST_DONE: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/tte_datapath.sv
// Cell store, cursor and span registers, and address engines of the engine.
module tte_datapath
  import tte_pkg::*;
#(
  parameter int SCREEN_COLS = DefaultCols,
  parameter int SCREEN_ROWS = DefaultRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [3:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [4:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  input  logic        text_color_we_i,
  input  logic [7:0]  text_color_i,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_color_o,
  output logic        done_o
);

  localparam int Cells = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(Cells + 1);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int LW    = $clog2(SCREEN_COLS);
  localparam logic [CW-1:0] ColsC    = CW'(SCREEN_COLS);
  localparam logic [CW-1:0] CellsC   = CW'(Cells);
  localparam logic [CW-1:0] OneC     = CW'(1);
  localparam logic [LW-1:0] LastCol  = LW'(SCREEN_COLS - 1);
  localparam logic [RW-1:0] LastRow  = RW'(SCREEN_ROWS - 1);
  localparam logic [5:0]    RowsC    = 6'(SCREEN_ROWS);
  localparam logic [7:0]    ColsRd   = 8'(SCREEN_COLS);

  logic [15:0] mem [Cells];
  logic [15:0] rdata_q;

  logic [3:0]  kind_q;
  logic [7:0]  char_q;
  logic [4:0]  rrow_q;
  logic [6:0]  rcol_q;
  logic [7:0]  color_q;

  logic [RW-1:0] cur_row_q, cur_row_d, end_row_q, end_row_d, st_row_q, st_row_d;
  logic [LW-1:0] cur_col_q, cur_col_d, end_col_q, end_col_d, st_col_q, st_col_d;
  logic [LW-1:0] scol_q;

  logic [CW-1:0] ptr_q, lim_q, stride_q, pend_addr_q;
  logic          pend_q;
  logic [CW-1:0] cur_lin, end_lin, st_lin, scan_lin;
  logic [CW-1:0] ld_ptr, ld_lim, ld_stride;

  logic          we;
  logic [CW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [CW-1:0] raddr;
  logic [7:0]    blank_color;
  logic          read_ok;

  assign cur_lin  = CW'(cur_row_q) * ColsC + CW'(cur_col_q);
  assign end_lin  = CW'(end_row_q) * ColsC + CW'(end_col_q);
  assign st_lin   = CW'(st_row_q) * ColsC + CW'(st_col_q);
  assign scan_lin = CW'(cur_row_q - RW'(1)) * ColsC + CW'(scol_q);
  assign read_ok  = ({1'b0, rrow_q} < RowsC) && ({1'b0, rcol_q} < ColsRd);

  // Input latch and colour register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ResetColor;
    end else if (text_color_we_i) begin
      color_q <= text_color_i;
    end
  end

  // Range selection for the fill and copy engines.
  always_comb begin
    ld_ptr = '0;
    ld_lim = CellsC;
    ld_stride = OneC;
    case (cmd_i.range)
      R_ALL: begin
        ld_ptr = '0;
        ld_lim = CellsC;
      end
      R_SCROLL: begin
        ld_ptr = '0;
        ld_lim = CellsC - ColsC;
        ld_stride = ColsC;
      end
      R_LAST_ROW: begin
        ld_ptr = CellsC - ColsC;
        ld_lim = CellsC;
      end
      R_SHIFT: begin
        ld_ptr = cur_lin - OneC;
        ld_lim = end_lin;
      end
      R_CUR: begin
        ld_ptr = cur_lin;
        ld_lim = cur_lin + OneC;
      end
      R_END: begin
        ld_ptr = end_lin;
        ld_lim = end_lin + OneC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      lim_q    <= CellsC;
      stride_q <= OneC;
      pend_q   <= 1'b0;
    end else begin
      pend_q <= cmd_i.copy_step;
      if (cmd_i.load) begin
        ptr_q    <= ld_ptr;
        lim_q    <= ld_lim;
        stride_q <= ld_stride;
      end else if (cmd_i.copy_step || cmd_i.fill_step) begin
        ptr_q <= ptr_q + OneC;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_step) pend_addr_q <= ptr_q;
  end

  // Store ports: one write, one registered read.
  assign blank_color = cmd_i.fill_init ? ResetColor : color_q;

  always_comb begin
    we = 1'b1;
    waddr = cur_lin;
    wdata = {color_q, char_q};
    if (pend_q) begin
      waddr = pend_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.fill_step) begin
      waddr = ptr_q;
      wdata = {blank_color, BlankChar};
    end else if (!cmd_i.wr_char) begin
      we = 1'b0;
    end
  end

  always_comb begin
    re = 1'b1;
    raddr = CW'(rrow_q) * ColsC + CW'(rcol_q);
    if (cmd_i.copy_step) raddr = ptr_q + stride_q;
    else if (cmd_i.scan_rd) raddr = scan_lin;
    else if (!cmd_i.cell_rd) re = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr[AW-1:0]] <= wdata;
    if (re) rdata_q <= mem[raddr[AW-1:0]];
  end

  // Cursor and span updates.
  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    end_row_d = end_row_q;
    end_col_d = end_col_q;
    st_row_d  = st_row_q;
    st_col_d  = st_col_q;
    case (cmd_i.cur_op)
      C_PUTC: begin
        if (char_q == NewlineChar || cur_col_q == LastCol) begin
          cur_col_d = '0;
          if (cur_row_q == LastRow) cur_row_d = LastRow;
          else cur_row_d = cur_row_q + RW'(1);
        end else begin
          cur_col_d = cur_col_q + LW'(1);
        end
        end_row_d = cur_row_d;
        end_col_d = cur_col_d;
      end
      C_BACK: begin
        if (cur_col_q == '0) begin
          cur_row_d = cur_row_q - RW'(1);
          cur_col_d = LastCol;
        end else begin
          cur_col_d = cur_col_q - LW'(1);
        end
        if (end_col_q != '0) begin
          end_col_d = end_col_q - LW'(1);
        end else if (end_row_q != '0) begin
          end_row_d = end_row_q - RW'(1);
          end_col_d = LastCol;
        end
      end
      C_LEFT_DEC: cur_col_d = cur_col_q - LW'(1);
      C_LEFT_HIT: begin
        cur_row_d = cur_row_q - RW'(1);
        cur_col_d = (scol_q == LastCol) ? LastCol : scol_q + LW'(1);
      end
      C_LEFT_MISS: begin
        cur_row_d = cur_row_q - RW'(1);
        cur_col_d = '0;
      end
      C_RIGHT: begin
        if (cur_row_q < end_row_q || (cur_row_q == end_row_q && cur_col_q < end_col_q)) begin
          if (cur_col_q != LastCol) begin
            cur_col_d = cur_col_q + LW'(1);
          end else if (cur_row_q < end_row_q) begin
            cur_row_d = cur_row_q + RW'(1);
            cur_col_d = '0;
          end
        end
      end
      C_DOWN: begin
        if (cur_row_q < end_row_q && cur_row_q != LastRow) cur_row_d = cur_row_q + RW'(1);
      end
      C_HOME: begin
        cur_row_d = '0;
        cur_col_d = '0;
      end
      C_MARK: begin
        st_row_d  = cur_row_q;
        st_col_d  = cur_col_q;
        end_row_d = cur_row_q;
        end_col_d = cur_col_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
      end_row_q <= '0;
      end_col_q <= '0;
      st_row_q  <= '0;
      st_col_q  <= '0;
      done_o    <= 1'b0;
    end else begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      end_row_q <= end_row_d;
      end_col_q <= end_col_d;
      st_row_q  <= st_row_d;
      st_col_q  <= st_col_d;
      done_o    <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) scol_q <= LastCol;
    else if (cmd_i.scan_dec) scol_q <= scol_q - LW'(1);
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cursor_row_o <= 5'(cur_row_q);
      cursor_col_o <= 7'(cur_col_q);
      if (kind_e'(kind_q) == K_READ && read_ok) begin
        cell_char_o  <= rdata_q[7:0];
        cell_color_o <= rdata_q[15:8];
      end else begin
        cell_char_o  <= '0;
        cell_color_o <= '0;
      end
    end
  end

  assign status_o.kind          = kind_q;
  assign status_o.is_newline    = (char_q == NewlineChar);
  assign status_o.need_scroll   = (char_q == NewlineChar || cur_col_q == LastCol)
                                  && cur_row_q == LastRow;
  assign status_o.cur_le_start  = (cur_lin <= st_lin);
  assign status_o.col_zero      = (cur_col_q == '0);
  assign status_o.read_ok       = read_ok;
  assign status_o.range_done    = (ptr_q >= lim_q);
  assign status_o.scan_hit      = (rdata_q[7:0] != BlankChar);
  assign status_o.scan_col_zero = (scol_q == '0);

endmodule

>>> rtl/text_terminal_engine.sv
// Top level of the text terminal engine: controller, datapath and checks.
//
// The engine keeps a screen of character cells with a cursor and an input
// span. An item is taken at a rising edge where start is high and busy is
// low; its single result appears for exactly one cycle with done_o high and
// cannot be held off, so the user must capture it in that cycle. After reset
// the engine sweeps the whole store to blanks, one cell per cycle, with busy
// high; the colour register may be written during the sweep. Clear blanks
// every cell, and a scrolling put-char copies each row up and blanks the last
// row, one cell at a time through the single write port of the cell store.
// Left from column zero reads the previous row from its end, cell by cell,
// until it finds a non-space or reaches its first cell. The user must see that
// colour writes are made only while the engine is idle; the block itself
// does not enforce this.
`include "assert_macros.svh"

module text_terminal_engine
  import tte_pkg::*;
#(
  parameter int SCREEN_COLS = DefaultCols,
  parameter int SCREEN_ROWS = DefaultRows
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] kind_i,
  input  logic [7:0] char_code_i,
  input  logic [4:0] read_row_i,
  input  logic [6:0] read_col_i,
  input  logic       text_color_we_i,
  input  logic [7:0] text_color_i,
  output logic [4:0] cursor_row_o,
  output logic [6:0] cursor_col_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_color_o,
  output logic       done_o
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences each item; the datapath owns the store, cursor and span state.
  tte_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  tte_datapath #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (kind_i),
    .char_code_i     (char_code_i),
    .read_row_i      (read_row_i),
    .read_col_i      (read_col_i),
    .text_color_we_i (text_color_we_i),
    .text_color_i    (text_color_i),
    .cursor_row_o    (cursor_row_o),
    .cursor_col_o    (cursor_col_o),
    .cell_char_o     (cell_char_o),
    .cell_color_o    (cell_color_o),
    .done_o          (done_o)
  );

  // A result is only ever shown once the engine has gone back to idle.
  `ASSERT_CLK(a_done_idle, done_o |-> !busy, "result shown while busy")
  // An accepted item always keeps the engine busy in the next cycle.
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted item not held")
  // Every item passes through the dispatch and done states, so results never come back to back.
  `ASSERT_NEVER(a_no_double, done_o && $past(done_o), "results back to back")
  // The reported cursor stays on the screen.
  `ASSERT_CLK(a_cursor_range,
    done_o |-> (32'(cursor_row_o) < SCREEN_ROWS && 32'(cursor_col_o) < SCREEN_COLS),
    "cursor off screen")

endmodule
